FILE: design/pd_pkg.sv
// Shared types and constants of the polyline densifier.
`default_nettype none

package pd_pkg;

   localparam int CoordW = 32;
   localparam int ResW   = 16;
   localparam int MulW   = 32;
   localparam int SumW   = 2 * CoordW + 1;

   localparam logic [ResW-1:0] ResReset = 16'd13;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

`default_nettype wire

FILE: design/pd_channels.sv
// Handshake channels of the polyline densifier: waypoints, points and register writes.
`default_nettype none

interface pd_req_if import pd_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      path_start;

   modport source (output valid, output point_x, output point_y, output path_start,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input path_start,
                   output ready);
endinterface

interface pd_rsp_if import pd_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   logic      run_last;

   modport source (output valid, output out_x, output out_y, output run_last,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input run_last,
                   output ready);
endinterface

interface pd_csr_if import pd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [ResW-1:0] grid_resolution;

   modport source (output valid, output grid_resolution, input ready);
   modport sink   (input valid, input grid_resolution, output ready);
endinterface

`default_nettype wire

FILE: design/pd_div_lane.sv
// Restoring divider lane that yields one quotient bit per cycle while step is asserted.
`default_nettype none

module pd_div_lane import pd_pkg::*; #(
   parameter int CW = 7
) (
   input  wire logic              clock,
   input  wire div_ctl_type       ctl,
   input  wire logic [CoordW-1:0] dividend,
   input  wire logic [CW-1:0]     divisor,
   output logic      [CoordW-1:0] quotient,
   output logic      [CW-1:0]     remainder
);

   logic [CoordW-1:0] quo_ff;
   logic [CW-1:0]     rem_ff;
   logic [CW:0]       trial;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[CoordW-1]};
      fits  = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (ctl.step) begin
         quo_ff <= {quo_ff[CoordW-2:0], fits};
         rem_ff <= fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: design/polyline_densifier.sv
// Top level of the polyline densifier: sequencer, shared multiplier and output register.
//
// Waypoints are taken one at a time while the block is idle. The first waypoint of a path
// is passed through as a single point; every later one is joined to the previous waypoint
// and the segment is cut into between 1 and MAX_STEPS equal steps, the last of which lands
// exactly on the new waypoint and is flagged with run_last. For a segment the shared 32 by
// 32 bit multiplier first forms the squared length and then squares the span of each step
// count tried; the bit-serial dividers then split the offsets, and each point is emitted in
// turn as the output takes it; a path start skips the multiplier. The next waypoint is
// accepted while the final point still waits at the output.
`default_nettype none

module polyline_densifier import pd_pkg::*; #(
   parameter int MAX_STEPS = 64
) (
   input wire logic clock,
   input wire logic reset,
   pd_req_if.sink   req_ch,
   pd_rsp_if.source rsp_ch,
   pd_csr_if.sink   csr_ch
);

   localparam int CW = $clog2(MAX_STEPS + 1);
   localparam int TW = ResW + CW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_TSQ, ST_CMP, ST_DIVL, ST_DIV, ST_STEP, ST_OUT
   } state_type;

   state_type state_ff;
   logic [ResW-1:0]   grid_res_ff;
   coord_type         prev_x_ff, prev_y_ff;
   logic              prev_valid_ff;
   coord_type         base_x_ff, base_y_ff;
   logic [CoordW-1:0] mag_x_ff, mag_y_ff;
   logic              neg_x_ff, neg_y_ff;
   logic [2*MulW-1:0] prod_ff;
   logic [SumW-1:0]   sum_ff;
   logic [TW-1:0]     t_ff;
   logic [CW-1:0]     n_ff, count_ff, k_ff;
   logic [4:0]        bit_ff;
   logic [CoordW-1:0] q_x_ff, q_y_ff;
   logic [CW-1:0]     rem_x_ff, rem_y_ff;
   logic              rsp_valid_ff;
   coord_type         out_x_ff, out_y_ff;
   logic              run_last_ff;

   logic [MulW-1:0]   mul_a, mul_b;
   logic [2*MulW-1:0] mul_p;
   logic [CoordW:0]   dx, dy;
   logic              seg_start;
   div_ctl_type       div_ctl;
   logic [CoordW-1:0] quo_x, quo_y;
   logic [CW-1:0]     rmd_x, rmd_y;
   logic [CW:0]       s_x, s_y;
   logic              out_load;

   always_comb begin
      dx = {req_ch.point_x[CoordW-1], req_ch.point_x} - {prev_x_ff[CoordW-1], prev_x_ff};
      dy = {req_ch.point_y[CoordW-1], req_ch.point_y} - {prev_y_ff[CoordW-1], prev_y_ff};
      seg_start = req_ch.path_start || !prev_valid_ff;
      case (state_ff)
         ST_SQX: begin
            mul_a = mag_x_ff;
            mul_b = mag_x_ff;
         end
         ST_SQY: begin
            mul_a = mag_y_ff;
            mul_b = mag_y_ff;
         end
         default: begin
            mul_a = {{(MulW-TW){1'b0}}, t_ff};
            mul_b = {{(MulW-TW){1'b0}}, t_ff};
         end
      endcase
      mul_p = {{MulW{1'b0}}, mul_a} * {{MulW{1'b0}}, mul_b};
      div_ctl.load = state_ff == ST_DIVL;
      div_ctl.step = state_ff == ST_DIV;
      s_x = {1'b0, rem_x_ff} + {1'b0, rmd_x};
      s_y = {1'b0, rem_y_ff} + {1'b0, rmd_y};
      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   pd_div_lane #(.CW(CW)) u_div_x (
      .clock, .ctl(div_ctl), .dividend(mag_x_ff), .divisor(count_ff),
      .quotient(quo_x), .remainder(rmd_x)
   );

   pd_div_lane #(.CW(CW)) u_div_y (
      .clock, .ctl(div_ctl), .dividend(mag_y_ff), .divisor(count_ff),
      .quotient(quo_y), .remainder(rmd_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         grid_res_ff   <= ResReset;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            grid_res_ff <= csr_ch.grid_resolution;
         end
         if (rsp_ch.ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  prev_x_ff     <= req_ch.point_x;
                  prev_y_ff     <= req_ch.point_y;
                  prev_valid_ff <= 1'b1;
                  neg_x_ff      <= dx[CoordW];
                  neg_y_ff      <= dy[CoordW];
                  count_ff      <= CW'(1);
                  if (seg_start) begin
                     base_x_ff <= req_ch.point_x;
                     base_y_ff <= req_ch.point_y;
                     mag_x_ff  <= '0;
                     mag_y_ff  <= '0;
                     state_ff  <= ST_DIVL;
                  end else begin
                     base_x_ff <= prev_x_ff;
                     base_y_ff <= prev_y_ff;
                     mag_x_ff  <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
                     mag_y_ff  <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
                     state_ff  <= ST_SQX;
                  end
               end
            end
            ST_SQX: begin
               prod_ff  <= mul_p;
               state_ff <= ST_SQY;
            end
            ST_SQY: begin
               prod_ff  <= mul_p;
               sum_ff   <= {1'b0, prod_ff};
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff   <= sum_ff + {1'b0, prod_ff};
               t_ff     <= {{CW{1'b0}}, grid_res_ff} + {{CW{1'b0}}, grid_res_ff};
               n_ff     <= CW'(2);
               state_ff <= (MAX_STEPS > 1) ? ST_TSQ : ST_DIVL;
            end
            ST_TSQ: begin
               prod_ff  <= mul_p;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if ({1'b0, prod_ff} <= sum_ff) begin
                  count_ff <= n_ff;
                  if (n_ff == CW'(MAX_STEPS)) begin
                     state_ff <= ST_DIVL;
                  end else begin
                     n_ff     <= n_ff + CW'(1);
                     t_ff     <= t_ff + {{CW{1'b0}}, grid_res_ff};
                     state_ff <= ST_TSQ;
                  end
               end else begin
                  state_ff <= ST_DIVL;
               end
            end
            ST_DIVL: begin
               bit_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               bit_ff <= bit_ff + 5'd1;
               if (bit_ff == 5'd31) begin
                  q_x_ff   <= '0;
                  q_y_ff   <= '0;
                  rem_x_ff <= '0;
                  rem_y_ff <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (s_x >= {1'b0, count_ff}) begin
                  rem_x_ff <= CW'(s_x - {1'b0, count_ff});
                  q_x_ff   <= q_x_ff + quo_x + CoordW'(1);
               end else begin
                  rem_x_ff <= s_x[CW-1:0];
                  q_x_ff   <= q_x_ff + quo_x;
               end
               if (s_y >= {1'b0, count_ff}) begin
                  rem_y_ff <= CW'(s_y - {1'b0, count_ff});
                  q_y_ff   <= q_y_ff + quo_y + CoordW'(1);
               end else begin
                  rem_y_ff <= s_y[CW-1:0];
                  q_y_ff   <= q_y_ff + quo_y;
               end
               k_ff     <= k_ff + CW'(1);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  out_x_ff     <= neg_x_ff ? base_x_ff - q_x_ff : base_x_ff + q_x_ff;
                  out_y_ff     <= neg_y_ff ? base_y_ff - q_y_ff : base_y_ff + q_y_ff;
                  run_last_ff  <= k_ff == count_ff;
                  state_ff     <= (k_ff == count_ff) ? ST_IDLE : ST_STEP;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready    = state_ff == ST_IDLE;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_x    = out_x_ff;
   assign rsp_ch.out_y    = out_y_ff;
   assign rsp_ch.run_last = run_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_OUT) |->
         (count_ff != '0 && count_ff <= CW'(MAX_STEPS)))
      else $error("Step count out of range.");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (k_ff != '0 && k_ff <= count_ff))
      else $error("Step index beyond the step count.");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (rem_x_ff < count_ff && rem_y_ff < count_ff))
      else $error("Step remainder not below the step count.");

   a_last_on_waypoint: assert property (@(posedge clock) disable iff (reset)
      (out_load && k_ff == count_ff) |=>
         (out_x_ff == prev_x_ff && out_y_ff == prev_y_ff && run_last_ff))
      else $error("Final point of a run misses its waypoint.");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the polyline densifier, with a point-by-point scoreboard.

module tb import pd_pkg::*; ();

   localparam int MaxSteps      = 64;
   localparam int HalfPeriod    = 6;
   localparam int ResetCycles   = 10;
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 400;
   localparam int HoldCycles    = 300;
   localparam int PrintLimit    = 40;

   typedef logic [SumW:0] square_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } point_type;

   class point_scoreboard;
      logic [ResW-1:0] resolution;
      coord_type       prev_x;
      coord_type       prev_y;
      logic            prev_valid;
      point_type       expected_points[$];
      int              errors;

      function new();
         resolution = ResReset;
         prev_x     = '0;
         prev_y     = '0;
         prev_valid = 1'b0;
         errors     = 0;
      endfunction

      function void set_resolution(logic [ResW-1:0] value);
         resolution = value;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function void note_waypoint(coord_type bx, coord_type by, logic start);
         longint     dx;
         longint     dy;
         logic [63:0] mag_x;
         logic [63:0] mag_y;
         square_type len_sq;
         square_type step_sq;
         int         steps;
         point_type  pt;
         if (start || !prev_valid) begin
            pt.x    = bx;
            pt.y    = by;
            pt.last = 1'b1;
            expected_points = {expected_points, pt};
         end else begin
            dx     = longint'(bx) - longint'(prev_x);
            dy     = longint'(by) - longint'(prev_y);
            mag_x  = (dx < 0) ? 64'(-dx) : 64'(dx);
            mag_y  = (dy < 0) ? 64'(-dy) : 64'(dy);
            len_sq = square_type'(mag_x) * square_type'(mag_x)
                     + square_type'(mag_y) * square_type'(mag_y);
            steps  = 1;
            for (int n = 2; n <= MaxSteps; n++) begin
               step_sq = square_type'(n * int'(resolution));
               step_sq = step_sq * step_sq;
               if (len_sq >= step_sq) begin
                  steps = n;
               end else begin
                  break;
               end
            end
            for (int k = 1; k <= steps; k++) begin
               pt.x    = prev_x + coord_type'((longint'(k) * dx) / longint'(steps));
               pt.y    = prev_y + coord_type'((longint'(k) * dy) / longint'(steps));
               pt.last = (k == steps);
               expected_points = {expected_points, pt};
            end
         end
         prev_x     = bx;
         prev_y     = by;
         prev_valid = 1'b1;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PrintLimit) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endtask

      task check_point(coord_type x, coord_type y, logic last);
         point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("unexpected point x=%0d y=%0d last=%0b", x, y, last));
            return;
         end
         want = expected_points.pop_front();
         if (x !== want.x) begin
            report($sformatf("out_x %0d, wanted %0d", x, want.x));
         end
         if (y !== want.y) begin
            report($sformatf("out_y %0d, wanted %0d", y, want.y));
         end
         if (last !== want.last) begin
            report($sformatf("run_last %0b, wanted %0b", last, want.last));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   pd_req_if req_if ();
   pd_rsp_if rsp_if ();
   pd_csr_if csr_if ();

   polyline_densifier #(
      .MAX_STEPS(MaxSteps)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   point_scoreboard sb = new();

   bit              idle_on;
   bit              stall_on;
   int              hold_count;
   int              holds_seen;
   int              hold_left;
   int              stall_left;
   int              quiet_cycles;
   logic [ResW-1:0] cur_res;
   coord_type       last_x;
   coord_type       last_y;

   initial begin
      clock = 1'b0;
      forever #HalfPeriod clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_count != holds_seen) begin
         holds_seen = hold_count;
         hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_point(rsp_if.out_x, rsp_if.out_y, rsp_if.run_last);
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_waypoint(req_if.point_x, req_if.point_y, req_if.path_start);
         end
         if (csr_if.valid && csr_if.ready) begin
            sb.set_resolution(csr_if.grid_resolution);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)
             || (csr_if.valid && csr_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("polyline_densifier regression: fail");
            $finish;
         end
      end
   end

   task automatic send_point(input coord_type px, input coord_type py, input logic start);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.point_x    <= px;
      req_if.point_y    <= py;
      req_if.path_start <= start;
      do @(posedge clock); while (!req_if.ready);
      last_x = px;
      last_y = py;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [ResW-1:0] value);
      wait_drained();
      csr_if.valid           <= 1'b1;
      csr_if.grid_resolution <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cur_res = value;
   endtask

   task automatic send_random_item();
      int     kind;
      int     steps_goal;
      longint span;
      longint len;
      longint dx;
      longint dy;
      longint nx;
      longint ny;
      logic   start;
      kind  = $urandom_range(0, 19);
      start = 1'b0;
      if (kind <= 2) begin
         start = (kind == 0);
         nx    = longint'(coord_type'($urandom));
         ny    = longint'(coord_type'($urandom));
      end else if (kind <= 5) begin
         nx = longint'(last_x) + longint'($urandom_range(0, 4000)) - 2000;
         ny = longint'(last_y) + longint'($urandom_range(0, 4000)) - 2000;
      end else begin
         steps_goal = $urandom_range(0, 70);
         span       = (cur_res == 0) ? 1 : longint'(cur_res);
         len        = steps_goal * span + longint'($urandom_range(0, int'(span) - 1));
         dx         = $urandom_range(0, 1) ? len : -len;
         dy         = longint'($urandom_range(0, int'(len / 4)));
         if ($urandom_range(0, 1)) begin
            dy = -dy;
         end
         if ($urandom_range(0, 1)) begin
            nx = longint'(last_x) + dx;
            ny = longint'(last_y) + dy;
         end else begin
            nx = longint'(last_x) + dy;
            ny = longint'(last_y) + dx;
         end
      end
      send_point(coord_type'(nx), coord_type'(ny), start);
   endtask

   task automatic send_random_run(input int count);
      repeat (count) send_random_item();
   endtask

   initial begin
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.point_x         = '0;
      req_if.point_y         = '0;
      req_if.path_start      = 1'b0;
      rsp_if.ready           = 1'b0;
      csr_if.valid           = 1'b0;
      csr_if.grid_resolution = '0;
      idle_on                = 1'b1;
      stall_on               = 1'b1;
      hold_count             = 0;
      holds_seen             = 0;
      hold_left              = 0;
      stall_left             = 0;
      quiet_cycles           = 0;
      cur_res                = ResReset;
      last_x                 = '0;
      last_y                 = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // A waypoint without a path start straight after reset opens a path.
      send_point(32'sh0000_1234, -32'sd837, 1'b0);
      send_point(32'sh0000_1234, -32'sd837, 1'b0);
      send_point(32'sh0000_1234 + 39, -32'sd837 + 52, 1'b0);
      send_point(coord_type'(32'h7FFF_FFFF), coord_type'(32'h7FFF_FFFF), 1'b0);
      send_point(coord_type'(32'h8000_0000), coord_type'(32'h8000_0000), 1'b0);
      send_point(coord_type'(32'h7FFF_FFFF), coord_type'(32'h8000_0000), 1'b0);
      send_point(coord_type'(32'h8000_0000), coord_type'(32'h7FFF_FFFF), 1'b1);
      send_point(-32'sd1, 32'sd1, 1'b0);
      send_point(-32'sd13, 32'sd1, 1'b0);
      send_point(-32'sd39, 32'sd1, 1'b0);
      send_point(coord_type'(32'h5555_5555), coord_type'(32'hAAAA_AAAA), 1'b1);
      send_point(coord_type'(32'hAAAA_AAAA), coord_type'(32'h5555_5555), 1'b0);

      // With a zero spacing even a zero-length segment saturates.
      write_resolution(16'd0);
      send_point(32'sd5, 32'sd5, 1'b1);
      send_point(32'sd5, 32'sd5, 1'b0);
      send_point(-32'sd7, 32'sd300, 1'b0);

      write_resolution(16'hFFFF);
      send_point(32'sd0, 32'sd0, 1'b1);
      send_point(32'sd4194240, 32'sd0, 1'b0);
      send_point(32'sd4194240, -32'sd131070, 1'b0);
      send_random_run(55);

      write_resolution(16'd1);
      send_random_run(22);
      wait_drained();
      send_random_run(23);

      write_resolution(ResW'($urandom_range(2, 65534)));
      hold_count++;
      send_random_run(30);
      wait_drained();
      send_random_run(30);

      write_resolution(16'd200);
      send_random_run(20);
      hold_count++;
      send_random_run(25);

      write_resolution(ResReset);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      send_random_run(45);

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected points never arrived", sb.pending()));
      end
      if (sb.errors == 0) begin
         $display("polyline_densifier regression: pass");
      end else begin
         $display("polyline_densifier regression: fail");
      end
      $finish;
   end

endmodule
